>>> design/trbq_pkg.sv
// trbq_pkg: shared types and codes for the task ready/blocked queue
// used by trbq_cell, trbq_chain and task_ready_blocked_queue
package trbq_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_RESUME = 2'd2;
  localparam logic [1:0] CMD_FIND   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_NOT_SUSP  = 3'd4;
  localparam logic [2:0] ST_BAD_PRIO  = 3'd5;

  localparam logic [3:0] MAX_PRIORITY_RESET = 4'd9;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] task_id;
    logic [3:0] priority_req;
    logic       is_blocked;
    logic       is_suspended;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found_queue;
    logic [3:0] position;
    logic [3:0] found_priority;
    logic       found_suspended;
  } out_item_t;

  typedef struct packed {
    logic [7:0] id;
    logic [3:0] prio;
    logic       susp;
  } entry_t;

  // per-cycle command broadcast to every cell of one chain
  typedef struct packed {
    logic   ins;       // insert new_entry, sorted or at head
    logic   sorted;    // sorted insert if 1, head insert if 0
    logic   del;       // remove the entry matching key
    logic   clr_susp;  // clear suspended mark of entry matching key
    logic [7:0] key;
    entry_t new_entry;
  } chain_op_t;

endpackage

>>> design/trbq_cell.sv
// trbq_cell: one queue slot holding valid, id, priority and suspended mark
// depends on trbq_pkg
module trbq_cell (
  input  logic               clk,
  input  logic               rst,
  input  trbq_pkg::chain_op_t op,
  input  logic               left_valid,
  input  trbq_pkg::entry_t   left_entry,
  input  logic               left_goes,   // left neighbor is at or beyond insert spot
  input  logic               left_hit,    // some cell left of here matches key
  input  logic               right_valid,
  input  trbq_pkg::entry_t   right_entry,
  output logic               valid,
  output trbq_pkg::entry_t   entry,
  output logic               goes,
  output logic               hit_out,
  output logic               hit
);

  logic             valid_next;
  trbq_pkg::entry_t entry_next;
  logic             here_goes;

  assign hit = valid && (entry.id == op.key);
  assign hit_out = left_hit || hit;
  // sorted: first cell whose prio exceeds new or is empty
  assign here_goes = op.sorted ? (!valid || (entry.prio > op.new_entry.prio)) : 1'b1;
  assign goes = left_goes || here_goes;

  always_comb begin
    valid_next = valid;
    entry_next = entry;
    if (op.ins) begin
      if (left_goes) begin
        valid_next = left_valid;
        entry_next = left_entry;
      end else if (here_goes) begin
        valid_next = 1'b1;
        entry_next = op.new_entry;
      end
    end else if (op.del) begin
      if (hit_out) begin
        valid_next = right_valid;
        entry_next = right_entry;
      end
    end else if (op.clr_susp && hit) begin
      entry_next.susp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    entry <= entry_next;
  end

endmodule

>>> design/trbq_chain.sv
// trbq_chain: a row of trbq_cell slots forming one queue with search results
// depends on trbq_pkg and trbq_cell
module trbq_chain #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  trbq_pkg::chain_op_t op,
  output logic                full,
  output logic                found,
  output logic [5:0]          found_pos,
  output trbq_pkg::entry_t    found_entry,
  output logic [5:0]          ins_pos
);

  logic             valid [DEPTH];
  trbq_pkg::entry_t entry [DEPTH];
  logic             goes  [DEPTH];
  logic             hito  [DEPTH];
  logic             hit   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             lv, rv, lg, lh;
    trbq_pkg::entry_t le, re;
    if (i == 0) begin : g_first
      assign lv = 1'b0;
      assign le = '0;
      assign lg = 1'b0;
      assign lh = 1'b0;
    end else begin : g_mid
      assign lv = valid[i-1];
      assign le = entry[i-1];
      assign lg = goes[i-1];
      assign lh = hito[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_inner
      assign rv = valid[i+1];
      assign re = entry[i+1];
    end
    trbq_cell u_cell (
      .clk(clk), .rst(rst), .op(op),
      .left_valid(lv), .left_entry(le), .left_goes(lg), .left_hit(lh),
      .right_valid(rv), .right_entry(re),
      .valid(valid[i]), .entry(entry[i]), .goes(goes[i]),
      .hit_out(hito[i]), .hit(hit[i])
    );
  end

  assign full = valid[DEPTH-1];
  assign found = hito[DEPTH-1];

  always_comb begin
    found_pos = '0;
    found_entry = '0;
    ins_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found_pos = 6'(i);
        found_entry = entry[i];
      end
      if (goes[i]) ins_pos = 6'(i);
    end
  end

endmodule

>>> design/task_ready_blocked_queue.sv
// task_ready_blocked_queue: two shift-cell task queues (ready sorted, blocked lifo)
// the command is registered on transfer; one command at a time and the input
//   stays stalled until the result transfers, so a new command waits for the
//   last result and for any output stall
// the exec state looks up both chains, applies the shift and loads the result
// reset: sync active high, queues empty, max_priority back to 9
// depends on trbq_pkg, trbq_chain, trbq_cell
module task_ready_blocked_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  trbq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output trbq_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;

  logic [1:0]          state;
  logic [3:0]          max_priority;
  trbq_pkg::in_item_t  cmd;
  trbq_pkg::chain_op_t rop, bop;
  logic                r_full, r_found, b_full, b_found;
  logic [5:0]          r_pos, b_pos, r_ins, b_ins;
  trbq_pkg::entry_t    r_ent, b_ent;
  trbq_pkg::out_item_t res;
  logic                go;
  trbq_pkg::entry_t    new_e;

  // accept only when idle and the result register is free
  assign in_stall = (state != S_IDLE) || out_valid;
  assign go = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_priority <= trbq_pkg::MAX_PRIORITY_RESET;
    end else if (cfg_we) begin
      max_priority <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) cmd <= in_data;
  end

  // decide the result and chain operations from the held command
  always_comb begin
    rop = '0;
    bop = '0;
    rop.key = cmd.task_id;
    bop.key = cmd.task_id;
    rop.sorted = 1'b1;
    new_e.id = cmd.task_id;
    new_e.prio = cmd.priority_req;
    new_e.susp = cmd.is_suspended;
    res = '0;
    // default: describe the found entry, ready queue first
    if (r_found) begin
      res.found_queue = 1'b0;
      res.position = r_pos[3:0];
      res.found_priority = r_ent.prio;
      res.found_suspended = r_ent.susp;
    end else if (b_found) begin
      res.found_queue = 1'b1;
      res.position = b_pos[3:0];
      res.found_priority = b_ent.prio;
      res.found_suspended = b_ent.susp;
    end
    case (cmd.command)
      trbq_pkg::CMD_INSERT: begin
        if (cmd.priority_req > max_priority) begin
          res = '0;
          res.status = trbq_pkg::ST_BAD_PRIO;
        end else if (r_found || b_found) begin
          res.status = trbq_pkg::ST_DUPLICATE;
        end else if (cmd.is_blocked ? b_full : r_full) begin
          res = '0;
          res.status = trbq_pkg::ST_FULL;
        end else begin
          res.status = trbq_pkg::ST_OK;
          res.found_queue = cmd.is_blocked;
          res.position = cmd.is_blocked ? 4'd0 : r_ins[3:0];
          res.found_priority = cmd.priority_req;
          res.found_suspended = cmd.is_suspended;
          rop.new_entry = new_e;
          bop.new_entry = new_e;
          rop.ins = go && !cmd.is_blocked;
          bop.ins = go && cmd.is_blocked;
        end
      end
      trbq_pkg::CMD_REMOVE: begin
        if (!(r_found || b_found)) begin
          res = '0;
          res.status = trbq_pkg::ST_NOT_FOUND;
        end else begin
          res.status = trbq_pkg::ST_OK;
          rop.del = go && r_found;
          bop.del = go && !r_found;
        end
      end
      trbq_pkg::CMD_RESUME: begin
        if (!(r_found || b_found)) begin
          res = '0;
          res.status = trbq_pkg::ST_NOT_FOUND;
        end else if (!res.found_suspended) begin
          res.status = trbq_pkg::ST_NOT_SUSP;
        end else if (r_found) begin
          res.status = trbq_pkg::ST_OK;
          res.found_suspended = 1'b0;
          rop.clr_susp = go;
        end else if (r_full) begin
          res.status = trbq_pkg::ST_FULL;
        end else begin
          // move blocked entry into ready queue at its priority
          rop.new_entry.id = cmd.task_id;
          rop.new_entry.prio = b_ent.prio;
          rop.new_entry.susp = 1'b0;
          bop.del = go;
          res.status = trbq_pkg::ST_OK;
          res.found_queue = 1'b0;
          res.found_suspended = 1'b0;
          res.position = r_ins[3:0];
          rop.ins = go;
        end
      end
      default: begin
        if (!(r_found || b_found)) begin
          res = '0;
          res.status = trbq_pkg::ST_NOT_FOUND;
        end else begin
          res.status = trbq_pkg::ST_OK;
        end
      end
    endcase
    // sorted spot search uses the new entry's priority even when idle
    if (!(rop.ins)) rop.new_entry.prio = (cmd.command == trbq_pkg::CMD_RESUME) ?
                                         b_ent.prio : cmd.priority_req;
  end

  trbq_chain #(.DEPTH(QUEUE_DEPTH)) u_ready (
    .clk(clk), .rst(rst), .op(rop), .full(r_full), .found(r_found),
    .found_pos(r_pos), .found_entry(r_ent), .ins_pos(r_ins)
  );

  trbq_chain #(.DEPTH(QUEUE_DEPTH)) u_blocked (
    .clk(clk), .rst(rst), .op(bop), .full(b_full), .found(b_found),
    .found_pos(b_pos), .found_entry(b_ent), .ins_pos(b_ins)
  );

  // blocked insert position is always the head
  logic unused_b_ins;
  assign unused_b_ins = ^b_ins;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) state <= S_EXEC;
        S_EXEC: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall) out_valid <= 1'b0;
    end
    if (go) out_data <= res;
  end

endmodule

>>> tb/trbq_checker.sv
// trbq_checker: watches both channels of the task queue, predicts each result
// from a private copy of both queues and compares; depends on trbq_pkg
module trbq_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  trbq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  trbq_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  trbq_pkg::entry_t    rdy_q[$];
  trbq_pkg::entry_t    blk_q[$];
  logic [3:0]          prio_limit;
  trbq_pkg::out_item_t expected_results[$];

  assign pending = expected_results.size();

  function automatic trbq_pkg::out_item_t describe(logic [2:0] st, bit q, int pos);
    trbq_pkg::out_item_t r;
    trbq_pkg::entry_t e;
    e = q ? blk_q[pos] : rdy_q[pos];
    r.status = st;
    r.found_queue = q;
    r.position = pos[3:0];
    r.found_priority = e.prio;
    r.found_suspended = e.susp;
    return r;
  endfunction

  function automatic int sorted_slot(logic [3:0] p);
    int k;
    k = 0;
    while (k < rdy_q.size() && rdy_q[k].prio <= p) k++;
    return k;
  endfunction

  function automatic trbq_pkg::out_item_t apply_command(trbq_pkg::in_item_t c);
    trbq_pkg::out_item_t r;
    trbq_pkg::entry_t e;
    bit hit;
    bit q;
    int pos;
    int k;
    r = '0;
    hit = 0;
    q = 0;
    pos = 0;
    for (k = 0; k < rdy_q.size() && !hit; k++)
      if (rdy_q[k].id == c.task_id) begin
        hit = 1; q = 0; pos = k;
      end
    for (k = 0; k < blk_q.size() && !hit; k++)
      if (blk_q[k].id == c.task_id) begin
        hit = 1; q = 1; pos = k;
      end
    if (c.command == trbq_pkg::CMD_INSERT) begin
      if (c.priority_req > prio_limit) begin
        r.status = trbq_pkg::ST_BAD_PRIO;
      end else if (hit) begin
        r = describe(trbq_pkg::ST_DUPLICATE, q, pos);
      end else if ((c.is_blocked ? blk_q.size() : rdy_q.size()) >= DEPTH) begin
        r.status = trbq_pkg::ST_FULL;
      end else begin
        e.id = c.task_id;
        e.prio = c.priority_req;
        e.susp = c.is_suspended;
        if (c.is_blocked) begin
          blk_q.push_front(e);
          r = describe(trbq_pkg::ST_OK, 1, 0);
        end else begin
          k = sorted_slot(e.prio);
          rdy_q.insert(k, e);
          r = describe(trbq_pkg::ST_OK, 0, k);
        end
      end
    end else if (!hit) begin
      r.status = trbq_pkg::ST_NOT_FOUND;
    end else if (c.command == trbq_pkg::CMD_REMOVE) begin
      r = describe(trbq_pkg::ST_OK, q, pos);
      if (q) blk_q.delete(pos);
      else rdy_q.delete(pos);
    end else if (c.command == trbq_pkg::CMD_RESUME) begin
      e = q ? blk_q[pos] : rdy_q[pos];
      if (!e.susp) begin
        r = describe(trbq_pkg::ST_NOT_SUSP, q, pos);
      end else if (!q) begin
        rdy_q[pos].susp = 1'b0;
        r = describe(trbq_pkg::ST_OK, 0, pos);
      end else if (rdy_q.size() >= DEPTH) begin
        r = describe(trbq_pkg::ST_FULL, 1, pos);
      end else begin
        blk_q.delete(pos);
        e.susp = 1'b0;
        k = sorted_slot(e.prio);
        rdy_q.insert(k, e);
        r = describe(trbq_pkg::ST_OK, 0, k);
      end
    end else begin
      r = describe(trbq_pkg::ST_OK, q, pos);
    end
    return r;
  endfunction

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    trbq_pkg::out_item_t want;
    if (rst) begin
      rdy_q.delete();
      blk_q.delete();
      expected_results.delete();
      prio_limit <= trbq_pkg::MAX_PRIORITY_RESET;
      fail_count = 0;
    end else begin
      if (cfg_we) prio_limit <= cfg_data;
      if (in_valid && !in_stall) expected_results.push_back(apply_command(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result, status %0d", out_data.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, out_data.status);
          compare_field("found_queue", want.found_queue, out_data.found_queue);
          compare_field("position", want.position, out_data.position);
          compare_field("found_priority", want.found_priority, out_data.found_priority);
          compare_field("found_suspended", want.found_suspended, out_data.found_suspended);
        end
      end
    end
  end

endmodule

>>> tb/task_ready_blocked_queue_tb.sv
// task_ready_blocked_queue_tb: stimulus and verdict for the task queue
// depends on trbq_pkg, trbq_checker and the task_ready_blocked_queue rtl
module task_ready_blocked_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  trbq_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  trbq_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [3:0]          cfg_data = '0;
  int                  fail_count;
  int                  pending;
  int                  directed_n = 0;
  int                  random_n = 0;
  bit                  calm = 0;   // no idling on either side while set

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task_ready_blocked_queue #(.QUEUE_DEPTH(16)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  trbq_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stalls at random, except in calm stretches
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 18);
  end

  // one transfer: optional idle gap first, then hold valid until accepted
  // valid is dropped by the next idle gap or by drain
  task automatic send_cmd(logic [1:0] c, logic [7:0] id, logic [3:0] p, bit b, bit s);
    trbq_pkg::in_item_t it;
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.command = c;
    it.task_id = id;
    it.priority_req = p;
    it.is_blocked = b;
    it.is_suspended = s;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait out every expected result plus the block's own latency
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random command biased toward a small id pool so hits are common
  task automatic random_cmd;
    logic [7:0] id;
    id = ($urandom_range(99) < 85) ? 8'($urandom_range(23)) : 8'($urandom);
    send_cmd(2'($urandom), id, 4'($urandom), 1'($urandom), 1'($urandom));
    random_n++;
  endtask

  initial begin
    int i;
    int phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every command, every status but full under reset limit of 9
    send_cmd(trbq_pkg::CMD_INSERT, 8'd0, 4'd9, 1'b0, 1'b1);    // top accepted priority
    send_cmd(trbq_pkg::CMD_INSERT, 8'd255, 4'd10, 1'b0, 1'b0); // bad priority
    send_cmd(trbq_pkg::CMD_INSERT, 8'd255, 4'd0, 1'b1, 1'b1);  // blocked head
    send_cmd(trbq_pkg::CMD_INSERT, 8'd0, 4'd3, 1'b1, 1'b0);    // duplicate
    send_cmd(trbq_pkg::CMD_INSERT, 8'd7, 4'd9, 1'b0, 1'b0);    // equal priority goes after
    send_cmd(trbq_pkg::CMD_FIND, 8'd7, 4'd0, 1'b0, 1'b0);
    send_cmd(trbq_pkg::CMD_FIND, 8'd99, 4'd15, 1'b1, 1'b1);    // not found
    send_cmd(trbq_pkg::CMD_RESUME, 8'd7, 4'd0, 1'b0, 1'b0);    // not suspended
    send_cmd(trbq_pkg::CMD_RESUME, 8'd0, 4'd0, 1'b0, 1'b0);    // ready task stays in place
    send_cmd(trbq_pkg::CMD_RESUME, 8'd255, 4'd0, 1'b0, 1'b0);  // blocked moves to ready
    send_cmd(trbq_pkg::CMD_REMOVE, 8'd0, 4'd0, 1'b0, 1'b0);
    send_cmd(trbq_pkg::CMD_REMOVE, 8'd0, 4'd0, 1'b0, 1'b0);    // remove twice: not found
    directed_n = 12;

    // fill both queues, then full on insert and on resume into full ready queue
    // ready already holds ids 255 and 7
    write_limit(4'd15);
    for (i = 0; i < 16; i++)
      send_cmd(trbq_pkg::CMD_INSERT, 8'(100 + i), 4'($urandom), 1'b1, 1'b1);
    for (i = 0; i < 13; i++)
      send_cmd(trbq_pkg::CMD_INSERT, 8'(120 + i), 4'($urandom), 1'b0, 1'b0);
    send_cmd(trbq_pkg::CMD_INSERT, 8'd200, 4'd15, 1'b1, 1'b0); // blocked full
    send_cmd(trbq_pkg::CMD_INSERT, 8'd201, 4'd15, 1'b0, 1'b0); // fills ready
    send_cmd(trbq_pkg::CMD_INSERT, 8'd202, 4'd0, 1'b0, 1'b0);  // ready full
    send_cmd(trbq_pkg::CMD_RESUME, 8'd105, 4'd0, 1'b0, 1'b0);  // resume blocked when ready full
    send_cmd(trbq_pkg::CMD_FIND, 8'd255, 4'd0, 1'b0, 1'b0);
    directed_n += 34;
    // empty everything again
    for (i = 0; i < 16; i++) send_cmd(trbq_pkg::CMD_REMOVE, 8'(100 + i), 4'd0, 1'b0, 1'b0);
    for (i = 0; i < 13; i++) send_cmd(trbq_pkg::CMD_REMOVE, 8'(120 + i), 4'd0, 1'b0, 1'b0);
    send_cmd(trbq_pkg::CMD_REMOVE, 8'd201, 4'd0, 1'b0, 1'b0);
    send_cmd(trbq_pkg::CMD_REMOVE, 8'd7, 4'd0, 1'b0, 1'b0);
    send_cmd(trbq_pkg::CMD_REMOVE, 8'd255, 4'd0, 1'b0, 1'b0);
    write_limit(4'd0);
    send_cmd(trbq_pkg::CMD_INSERT, 8'd3, 4'd1, 1'b0, 1'b0);    // bad under limit 0
    send_cmd(trbq_pkg::CMD_INSERT, 8'd3, 4'd0, 1'b0, 1'b1);
    send_cmd(trbq_pkg::CMD_REMOVE, 8'd3, 4'd0, 1'b0, 1'b0);
    directed_n += 35;

    // random phases across several limits, one of them without idling
    for (phase = 0; phase < 7; phase++) begin
      write_limit(phase == 0 ? 4'd15 : phase == 1 ? 4'd0 : 4'($urandom));
      calm = (phase == 3);
      for (i = 0; i < 190; i++) random_cmd();
      calm = 0;
    end

    drain();
    $display("covered %0d directed and %0d random commands over several priority limits",
             directed_n, random_n);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
